### src/msm_pkg.sv
package msm_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ACT_W = 2;
  localparam int STS_W = 2;
  localparam int ECNT_W = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd2;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

### src/msm_if.sv
interface msm_in_if;
  import msm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface msm_out_if;
  import msm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] top_value;
  logic [ECNT_W-1:0]       entry_count;
  logic                    is_empty;
  logic [STS_W-1:0]        status;

  modport source (output valid, top_value, entry_count, is_empty, status, input ready);
  modport sink (input valid, top_value, entry_count, is_empty, status, output ready);
endinterface

### src/msm_cell.sv
module msm_cell (
  input  logic                             clk,
  input  msm_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic                             up_lt,
  input  logic signed [msm_pkg::VAL_W-1:0] up_val,
  input  logic signed [msm_pkg::VAL_W-1:0] dn_val,
  output logic signed [msm_pkg::VAL_W-1:0] val,
  output logic                             lt
);
  import msm_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // A stored value strictly below the incoming one stays where it is.
  assign lt  = occupied && (val_r < ctrl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.push) begin
      if (!lt) begin
        val_nxt = up_lt ? ctrl.value : up_val;
      end
    end else if (ctrl.pop) begin
      val_nxt = dn_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### src/sorted_min_stack_top.sv
// Channel   | Direction | Payload                                      | Handshake
// ----------+-----------+----------------------------------------------+-------------
// in_ch     | sink      | action, value                                | valid/ready
// out_ch    | source    | top_value, entry_count, is_empty, status     | valid/ready
//
// Each accepted transaction is handled at once: every cell compares and shifts in parallel,
// and its result appears in the output register on the following cycle.
// A new transaction is taken whenever the output register is empty or being drained, so
// the sustained rate is one transaction per cycle, set by the output register handshake.
// Reset (rst_n, synchronous, active low) clears the entry count and the output valid flag;
// cell contents are not reset and are only read below the entry count.
// A stall on out_ch holds the result and the whole chain until it is taken.
module sorted_min_stack_top (
  input  logic      clk,
  input  logic      rst_n,
  msm_in_if.sink    in_ch,
  msm_out_if.source out_ch
);
  import msm_pkg::*;

  // Cell 0 holds the smallest value (the top); higher cells hold larger values.
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic                    cell_lt  [DEPTH];
  logic                    cell_occ [DEPTH];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [STS_W-1:0] status_r;
  logic [STS_W-1:0] status_nxt;

  logic       accept;
  logic       is_full;
  logic       is_none;
  cell_ctrl_t ctrl;

  logic [CNT_W+ECNT_W-1:0] count_wide;

  // A transaction may enter when no result waits or the waiting one leaves now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_full = (count_r == CNT_W'(DEPTH));
  assign is_none = (count_r == '0);

  always_comb begin
    ctrl.push  = 1'b0;
    ctrl.pop   = 1'b0;
    ctrl.value = in_ch.value;
    count_nxt  = count_r;
    status_nxt = STS_OK;
    if (accept) begin
      case (in_ch.action)
        ACT_PUSH: begin
          if (is_full) begin
            status_nxt = STS_OVERFLOW;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_POP: begin
          if (is_none) begin
            status_nxt = STS_UNDERFLOW;
          end else begin
            ctrl.pop  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        // A read, and the unused code, leave the store as it is.
        default: begin
          status_nxt = STS_OK;
        end
      endcase
    end
  end

  // The chain: each cell sees its upper neighbour for a push and its lower one for a pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    up_lt;
    logic signed [VAL_W-1:0] up_val;
    logic signed [VAL_W-1:0] dn_val;

    assign cell_occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign up_lt  = 1'b1;
      assign up_val = '0;
    end else begin : g_inner
      assign up_lt  = cell_lt[i-1];
      assign up_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_val = '0;
    end else begin : g_body
      assign dn_val = cell_val[i+1];
    end

    msm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (cell_occ[i]),
      .up_lt    (up_lt),
      .up_val   (up_val),
      .dn_val   (dn_val),
      .val      (cell_val[i]),
      .lt       (cell_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // The chain only moves on an accepted transaction, and that happens only when no result
  // waits or the pending one leaves, so the cells and the count describe the waiting result.
  assign count_wide = {{ECNT_W{1'b0}}, count_r};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = is_none ? '0 : cell_val[0];
  assign out_ch.entry_count = count_wide[ECNT_W-1:0];
  assign out_ch.is_empty    = is_none;
  assign out_ch.status      = status_r;

endmodule
